>>> hdl/ltc_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the LRU tag cache.
package ltc_pkg;

   localparam int CAP_W     = 5;
   localparam int CNT_W     = 32;
   localparam int OP_W      = 3;
   localparam int CSR_IDX_W = 1;

   localparam logic [OP_W-1:0] OP_GET    = 3'd0;
   localparam logic [OP_W-1:0] OP_PUT    = 3'd1;
   localparam logic [OP_W-1:0] OP_HAS    = 3'd2;
   localparam logic [OP_W-1:0] OP_REMOVE = 3'd3;
   localparam logic [OP_W-1:0] OP_CLEAR  = 3'd4;
   localparam logic [OP_W-1:0] OP_FLUSH  = 3'd5;
   localparam logic [OP_W-1:0] OP_STATS  = 3'd6;

   localparam logic [CSR_IDX_W-1:0] CSR_CAPACITY = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_REPORT   = 1'b1;

   localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;
   localparam logic [CNT_W-1:0] CNT_MAX   = '1;

   typedef struct packed {
      logic take_item;
      logic exec;
      logic start_walk;
      logic walk_step;
   } ltc_cmd_type;

   typedef struct packed {
      logic walk_needed;
      logic walk_last;
   } ltc_sts_type;

endpackage

>>> hdl/ltc_if.sv
`timescale 1ns / 1ps
// Request and response channel interfaces for the LRU tag cache.
interface ltc_req_if #(
   parameter int KEY_BITS   = 32,
   parameter int VALUE_BITS = 32
);
   logic                  valid;
   logic                  ready;
   logic [2:0]            op;
   logic [KEY_BITS-1:0]   key_tag;
   logic [VALUE_BITS-1:0] value_in;

   modport source (output valid, output op, output key_tag, output value_in, input ready);
   modport sink   (input valid, input op, input key_tag, input value_in, output ready);
endinterface

interface ltc_rsp_if #(
   parameter int ENTRIES    = 16,
   parameter int KEY_BITS   = 32,
   parameter int VALUE_BITS = 32
);
   localparam int OCC_W = $clog2(ENTRIES + 1);

   logic                  valid;
   logic                  ready;
   logic                  found;
   logic [VALUE_BITS-1:0] value_out;
   logic [OCC_W-1:0]      entry_count;
   logic [31:0]           hit_total;
   logic [31:0]           miss_total;
   logic                  report_valid;
   logic [KEY_BITS-1:0]   report_key;
   logic [VALUE_BITS-1:0] report_value;
   logic                  last;

   modport source (output valid, output found, output value_out, output entry_count,
                   output hit_total, output miss_total, output report_valid,
                   output report_key, output report_value, output last, input ready);
   modport sink   (input valid, input found, input value_out, input entry_count,
                   input hit_total, input miss_total, input report_valid,
                   input report_key, input report_value, input last, output ready);
endinterface

>>> hdl/ltc_datapath.sv
`timescale 1ns / 1ps
// Datapath: entry stores, tag compare, recency ranks, counters and result register.
module ltc_datapath #(
   parameter int ENTRIES    = 16,
   parameter int KEY_BITS   = 32,
   parameter int VALUE_BITS = 32,
   localparam int OCC_W     = $clog2(ENTRIES + 1)
) (
   input  logic                                clock,
   input  logic                                reset,
   input  ltc_pkg::ltc_cmd_type                cmd,
   output ltc_pkg::ltc_sts_type                sts,
   input  logic [ltc_pkg::OP_W-1:0]            req_op,
   input  logic [KEY_BITS-1:0]                 req_key_tag,
   input  logic [VALUE_BITS-1:0]               req_value_in,
   input  logic                                csr_wr_en,
   input  logic [ltc_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [ltc_pkg::CAP_W-1:0]           csr_wr_data,
   output logic                                found,
   output logic [VALUE_BITS-1:0]               value_out,
   output logic [OCC_W-1:0]                    entry_count,
   output logic [ltc_pkg::CNT_W-1:0]           hit_total,
   output logic [ltc_pkg::CNT_W-1:0]           miss_total,
   output logic                                report_valid,
   output logic [KEY_BITS-1:0]                 report_key,
   output logic [VALUE_BITS-1:0]               report_value,
   output logic                                last
);
   import ltc_pkg::*;

   localparam int RANK_W = $clog2(ENTRIES);

   logic [OP_W-1:0]       item_op_ff;
   logic [KEY_BITS-1:0]   item_key_ff;
   logic [VALUE_BITS-1:0] item_val_ff;
   logic [CAP_W-1:0]      cap_ff;
   logic                  rep_ff;

   logic [KEY_BITS-1:0]   tag_ff  [ENTRIES];
   logic [KEY_BITS-1:0]   tag_in  [ENTRIES];
   logic [VALUE_BITS-1:0] val_ff  [ENTRIES];
   logic [VALUE_BITS-1:0] val_in  [ENTRIES];
   logic [RANK_W-1:0]     rank_ff [ENTRIES];
   logic [RANK_W-1:0]     rank_in [ENTRIES];
   logic [ENTRIES-1:0]    valid_ff, valid_in;
   logic [OCC_W-1:0]      occ_ff, occ_in;
   logic [CNT_W-1:0]      hit_ff, hit_in, miss_ff, miss_in;
   logic [RANK_W-1:0]     walk_r_ff, walk_r_in;

   logic                  o_found_ff, o_found_in;
   logic [VALUE_BITS-1:0] o_value_ff, o_value_in;
   logic [OCC_W-1:0]      o_count_ff, o_count_in;
   logic [CNT_W-1:0]      o_hit_ff, o_hit_in, o_miss_ff, o_miss_in;
   logic                  o_rv_ff, o_rv_in;
   logic [KEY_BITS-1:0]   o_rk_ff, o_rk_in;
   logic [VALUE_BITS-1:0] o_rval_ff, o_rval_in;
   logic                  o_last_ff, o_last_in;

   logic [ENTRIES-1:0]    hit_vec, old_vec, walk_vec, free_vec;
   logic [RANK_W-1:0]     hit_idx, old_idx, walk_idx, slot_idx, rd_idx, hit_rank, occ_m1;
   logic                  hit, at_cap, evict, walk_last;
   logic [KEY_BITS-1:0]   rd_tag;
   logic [VALUE_BITS-1:0] rd_val;

   assign occ_m1    = RANK_W'(occ_ff - OCC_W'(1));
   assign hit       = |hit_vec;
   assign walk_last = (walk_r_ff == occ_m1);
   assign evict     = at_cap && (occ_ff != '0);

   always_comb begin
      at_cap = 1'b0;
      if (cap_ff == '0) begin
         at_cap = (occ_ff != '0);
      end else if (32'(cap_ff) > 32'(ENTRIES)) begin
         at_cap = (32'(occ_ff) >= 32'(ENTRIES));
      end else begin
         at_cap = (32'(occ_ff) >= 32'(cap_ff));
      end
   end

   always_comb begin
      hit_idx  = '0;
      old_idx  = '0;
      walk_idx = '0;
      slot_idx = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         hit_vec[i]  = valid_ff[i] && (tag_ff[i] == item_key_ff);
         old_vec[i]  = valid_ff[i] && (rank_ff[i] == occ_m1);
         walk_vec[i] = valid_ff[i] && (rank_ff[i] == walk_r_ff);
         free_vec[i] = !valid_ff[i] || (evict && old_vec[i]);
         if (hit_vec[i]) begin
            hit_idx = hit_idx | RANK_W'(i);
         end
         if (old_vec[i]) begin
            old_idx = old_idx | RANK_W'(i);
         end
         if (walk_vec[i]) begin
            walk_idx = walk_idx | RANK_W'(i);
         end
      end
      for (int i = ENTRIES - 1; i >= 0; i--) begin
         if (free_vec[i]) begin
            slot_idx = RANK_W'(i);
         end
      end
   end

   always_comb begin
      if (cmd.walk_step) begin
         rd_idx = walk_idx;
      end else if (item_op_ff == OP_PUT && !hit) begin
         rd_idx = old_idx;
      end else begin
         rd_idx = hit_idx;
      end
   end

   assign rd_tag   = tag_ff[rd_idx];
   assign rd_val   = val_ff[rd_idx];
   assign hit_rank = rank_ff[hit_idx];

   assign sts.walk_needed = rep_ff && (occ_ff != '0) &&
                            (item_op_ff == OP_CLEAR || item_op_ff == OP_FLUSH);
   assign sts.walk_last   = walk_last;

   always_comb begin
      tag_in     = tag_ff;
      val_in     = val_ff;
      rank_in    = rank_ff;
      valid_in   = valid_ff;
      occ_in     = occ_ff;
      hit_in     = hit_ff;
      miss_in    = miss_ff;
      walk_r_in  = walk_r_ff;
      o_found_in = o_found_ff;
      o_value_in = o_value_ff;
      o_count_in = o_count_ff;
      o_hit_in   = o_hit_ff;
      o_miss_in  = o_miss_ff;
      o_rv_in    = o_rv_ff;
      o_rk_in    = o_rk_ff;
      o_rval_in  = o_rval_ff;
      o_last_in  = o_last_ff;

      if (cmd.exec) begin
         o_found_in = 1'b0;
         o_value_in = '0;
         o_rv_in    = 1'b0;
         o_rk_in    = '0;
         o_rval_in  = '0;
         o_last_in  = 1'b1;
         case (item_op_ff)
            OP_GET: begin
               if (hit) begin
                  hit_in = (hit_ff == CNT_MAX) ? hit_ff : hit_ff + CNT_W'(1);
                  for (int j = 0; j < ENTRIES; j++) begin
                     if (valid_ff[j] && rank_ff[j] < hit_rank) begin
                        rank_in[j] = rank_ff[j] + RANK_W'(1);
                     end
                  end
                  rank_in[hit_idx] = '0;
                  o_found_in = 1'b1;
                  o_value_in = rd_val;
               end else begin
                  miss_in = (miss_ff == CNT_MAX) ? miss_ff : miss_ff + CNT_W'(1);
               end
            end
            OP_PUT: begin
               if (hit) begin
                  val_in[hit_idx] = item_val_ff;
                  for (int j = 0; j < ENTRIES; j++) begin
                     if (valid_ff[j] && rank_ff[j] < hit_rank) begin
                        rank_in[j] = rank_ff[j] + RANK_W'(1);
                     end
                  end
                  rank_in[hit_idx] = '0;
               end else begin
                  for (int j = 0; j < ENTRIES; j++) begin
                     if (valid_ff[j] && !(evict && old_vec[j])) begin
                        rank_in[j] = rank_ff[j] + RANK_W'(1);
                     end
                  end
                  if (evict) begin
                     valid_in[old_idx] = 1'b0;
                     o_rv_in = rep_ff;
                     if (rep_ff) begin
                        o_rk_in   = rd_tag;
                        o_rval_in = rd_val;
                     end
                  end
                  valid_in[slot_idx] = 1'b1;
                  tag_in[slot_idx]   = item_key_ff;
                  val_in[slot_idx]   = item_val_ff;
                  rank_in[slot_idx]  = '0;
                  occ_in = evict ? occ_ff : occ_ff + OCC_W'(1);
               end
            end
            OP_HAS: begin
               o_found_in = hit;
            end
            OP_REMOVE: begin
               if (hit) begin
                  valid_in[hit_idx] = 1'b0;
                  for (int j = 0; j < ENTRIES; j++) begin
                     if (valid_ff[j] && rank_ff[j] > hit_rank) begin
                        rank_in[j] = rank_ff[j] - RANK_W'(1);
                     end
                  end
                  occ_in = occ_ff - OCC_W'(1);
               end
            end
            OP_CLEAR: begin
               valid_in = '0;
               occ_in   = '0;
            end
            OP_STATS: begin
               hit_in  = '0;
               miss_in = '0;
            end
            default: begin
            end
         endcase
         o_count_in = occ_in;
         o_hit_in   = hit_in;
         o_miss_in  = miss_in;
      end

      if (cmd.start_walk) begin
         walk_r_in = '0;
      end

      if (cmd.walk_step) begin
         o_found_in = 1'b0;
         o_value_in = '0;
         o_rv_in    = 1'b1;
         o_rk_in    = rd_tag;
         o_rval_in  = rd_val;
         o_last_in  = walk_last;
         o_hit_in   = hit_ff;
         o_miss_in  = miss_ff;
         walk_r_in  = walk_r_ff + RANK_W'(1);
         if (item_op_ff == OP_CLEAR) begin
            o_count_in = '0;
            if (walk_last) begin
               valid_in = '0;
               occ_in   = '0;
            end
         end else begin
            o_count_in = occ_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff    <= CAP_RESET;
         rep_ff    <= 1'b1;
         valid_ff  <= '0;
         occ_ff    <= '0;
         hit_ff    <= '0;
         miss_ff   <= '0;
         walk_r_ff <= '0;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_CAPACITY: cap_ff <= csr_wr_data;
               CSR_REPORT:   rep_ff <= csr_wr_data[0];
               default: begin
               end
            endcase
         end
         valid_ff  <= valid_in;
         occ_ff    <= occ_in;
         hit_ff    <= hit_in;
         miss_ff   <= miss_in;
         walk_r_ff <= walk_r_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take_item) begin
         item_op_ff  <= req_op;
         item_key_ff <= req_key_tag;
         item_val_ff <= req_value_in;
      end
      tag_ff     <= tag_in;
      val_ff     <= val_in;
      rank_ff    <= rank_in;
      o_found_ff <= o_found_in;
      o_value_ff <= o_value_in;
      o_count_ff <= o_count_in;
      o_hit_ff   <= o_hit_in;
      o_miss_ff  <= o_miss_in;
      o_rv_ff    <= o_rv_in;
      o_rk_ff    <= o_rk_in;
      o_rval_ff  <= o_rval_in;
      o_last_ff  <= o_last_in;
   end

   assign found        = o_found_ff;
   assign value_out    = o_value_ff;
   assign entry_count  = o_count_ff;
   assign hit_total    = o_hit_ff;
   assign miss_total   = o_miss_ff;
   assign report_valid = o_rv_ff;
   assign report_key   = o_rk_ff;
   assign report_value = o_rval_ff;
   assign last         = o_last_ff;

endmodule

>>> hdl/ltc_ctrl.sv
`timescale 1ns / 1ps
// Controller: sequences accept, execute and report walk, and owns the response valid.
module ltc_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output ltc_pkg::ltc_cmd_type cmd,
   input  ltc_pkg::ltc_sts_type sts
);
   import ltc_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_WALK
   } state_type;

   state_type state_ff;
   logic      rsp_valid_ff;
   logic      out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd = '0;
      case (state_ff)
         ST_IDLE: cmd.take_item = req_valid;
         ST_EXEC: begin
            if (out_free) begin
               if (sts.walk_needed) begin
                  cmd.start_walk = 1'b1;
               end else begin
                  cmd.exec = 1'b1;
               end
            end
         end
         ST_WALK: cmd.walk_step = out_free;
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.exec || cmd.walk_step || (rsp_valid_ff && !rsp_ready);
         case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  state_ff <= ST_EXEC;
               end
            end
            ST_EXEC: begin
               if (out_free) begin
                  state_ff <= sts.walk_needed ? ST_WALK : ST_IDLE;
               end
            end
            ST_WALK: begin
               if (out_free && sts.walk_last) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule

>>> hdl/lru_tag_cache.sv
`timescale 1ns / 1ps
// Top level of the fully associative LRU tag cache.
//
//   channel   dir  handshake          beat
//   req_chan  in   valid/ready        op, key_tag, value_in
//   rsp_chan  out  valid/ready        found .. last, one or more per request
//   csr_*     in   csr_wr_en          capacity_limit (0), report_enable (1)
//
// A request is accepted first, then all tags are compared and the entries updated.
// Clear or flush with reporting walks the N live entries, one beat each.
// Reset is synchronous; valid bits, occupancy and counters clear at once.
// Execute and walk steps hold while the result register is full and not taken.
module lru_tag_cache #(
   parameter int ENTRIES    = 16,
   parameter int KEY_BITS   = 32,
   parameter int VALUE_BITS = 32
) (
   input  logic                                 clock,
   input  logic                                 reset,
   ltc_req_if.sink                              req_chan,
   ltc_rsp_if.source                            rsp_chan,
   input  logic                                 csr_wr_en,
   input  logic [ltc_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [ltc_pkg::CAP_W-1:0]            csr_wr_data
);
   import ltc_pkg::*;

   ltc_cmd_type cmd;
   ltc_sts_type sts;

   ltc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   ltc_datapath #(
      .ENTRIES    (ENTRIES),
      .KEY_BITS   (KEY_BITS),
      .VALUE_BITS (VALUE_BITS)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .sts          (sts),
      .req_op       (req_chan.op),
      .req_key_tag  (req_chan.key_tag),
      .req_value_in (req_chan.value_in),
      .csr_wr_en    (csr_wr_en),
      .csr_index    (csr_index),
      .csr_wr_data  (csr_wr_data),
      .found        (rsp_chan.found),
      .value_out    (rsp_chan.value_out),
      .entry_count  (rsp_chan.entry_count),
      .hit_total    (rsp_chan.hit_total),
      .miss_total   (rsp_chan.miss_total),
      .report_valid (rsp_chan.report_valid),
      .report_key   (rsp_chan.report_key),
      .report_value (rsp_chan.report_value),
      .last         (rsp_chan.last)
   );

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> !req_chan.ready)
      else $error("request accepted while another is in flight");

   a_status_single: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && !rsp_chan.report_valid) |-> rsp_chan.last)
      else $error("status beat without last");

   a_found_no_report: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.found) |-> !rsp_chan.report_valid)
      else $error("hit beat also carries a report");

   a_exec_loads: assert property (@(posedge clock) disable iff (reset)
      (cmd.exec || cmd.walk_step) |=> rsp_chan.valid)
      else $error("result register not loaded after execute");

endmodule

>>> verif/lru_tag_cache_tb.sv
`timescale 1ns / 1ps
// Testbench for the LRU tag cache: directed table, then random traffic checked by a predictor.
module lru_tag_cache_tb;
   import ltc_pkg::*;

   localparam int ENTRIES    = 16;
   localparam int KEY_POOL   = 20;
   localparam int PHASES     = 5;
   localparam int PHASE_REQS = 52;
   localparam int IDLE_LIMIT = 2000;
   localparam int HOLD_LEN   = 60;

   localparam logic [OP_W-1:0] OP_UNUSED = 3'd7;

   typedef enum logic {ROW_ITEM, ROW_CSR} row_kind_type;

   typedef struct packed {
      logic        found;
      logic [31:0] value_out;
      logic [4:0]  entry_count;
      logic [31:0] hit_total;
      logic [31:0] miss_total;
      logic        report_valid;
      logic [31:0] report_key;
      logic [31:0] report_value;
      logic        last;
   } cache_beat_type;

   // CSR rows carry the register index in key and the data in val.
   typedef struct {
      row_kind_type    kind;
      logic [OP_W-1:0] op;
      logic [31:0]     key;
      logic [31:0]     val;
      logic            lit;
      logic            found;
      logic [31:0]     value_out;
      logic [4:0]      count;
      logic [31:0]     hits;
      logic [31:0]     misses;
   } stim_row_type;

   localparam int N_DIRECTED = 26;
   stim_row_type directed [N_DIRECTED] = '{
      '{ROW_ITEM, OP_GET,    32'h0,        32'h0,        1'b1, 1'b0, 32'h0, 5'd0, 32'd0, 32'd1},
      '{ROW_ITEM, OP_HAS,    32'hFFFFFFFF, 32'h0,        1'b1, 1'b0, 32'h0, 5'd0, 32'd0, 32'd1},
      '{ROW_ITEM, OP_CLEAR,  32'h0,        32'h0,        1'b1, 1'b0, 32'h0, 5'd0, 32'd0, 32'd1},
      '{ROW_ITEM, OP_FLUSH,  32'h0,        32'h0,        1'b1, 1'b0, 32'h0, 5'd0, 32'd0, 32'd1},
      '{ROW_ITEM, OP_REMOVE, 32'h5,        32'h0,        1'b1, 1'b0, 32'h0, 5'd0, 32'd0, 32'd1},
      '{ROW_ITEM, OP_PUT,    32'h0,        32'h0,        1'b1, 1'b0, 32'h0, 5'd1, 32'd0, 32'd1},
      '{ROW_ITEM, OP_PUT,    32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1, 1'b0, 32'h0, 5'd2, 32'd0, 32'd1},
      '{ROW_ITEM, OP_GET,    32'hFFFFFFFF, 32'h0,        1'b1, 1'b1, 32'hFFFFFFFF, 5'd2,
        32'd1, 32'd1},
      '{ROW_ITEM, OP_PUT,    32'h0,        32'h89ABCDEF, 1'b0, 1'b0, 32'h0, 5'd0, 32'd0, 32'd0},
      '{ROW_ITEM, OP_GET,    32'h0,        32'h0,        1'b0, 1'b0, 32'h0, 5'd0, 32'd0, 32'd0},
      '{ROW_ITEM, OP_HAS,    32'h0,        32'h0,        1'b0, 1'b0, 32'h0, 5'd0, 32'd0, 32'd0},
      '{ROW_ITEM, OP_PUT,    32'h1,        32'h80000000, 1'b0, 1'b0, 32'h0, 5'd0, 32'd0, 32'd0},
      '{ROW_ITEM, OP_FLUSH,  32'h0,        32'h0,        1'b0, 1'b0, 32'h0, 5'd0, 32'd0, 32'd0},
      '{ROW_ITEM, OP_UNUSED, 32'h1,        32'h1,        1'b0, 1'b0, 32'h0, 5'd0, 32'd0, 32'd0},
      '{ROW_ITEM, OP_STATS,  32'h0,        32'h0,        1'b1, 1'b0, 32'h0, 5'd3, 32'd0, 32'd0},
      '{ROW_ITEM, OP_REMOVE, 32'hFFFFFFFF, 32'h0,        1'b0, 1'b0, 32'h0, 5'd0, 32'd0, 32'd0},
      '{ROW_CSR,  OP_GET,    32'(CSR_CAPACITY), 32'd1,   1'b0, 1'b0, 32'h0, 5'd0, 32'd0, 32'd0},
      '{ROW_ITEM, OP_PUT,    32'h7,        32'h7,        1'b0, 1'b0, 32'h0, 5'd0, 32'd0, 32'd0},
      '{ROW_ITEM, OP_PUT,    32'h8,        32'h55555555, 1'b0, 1'b0, 32'h0, 5'd0, 32'd0, 32'd0},
      '{ROW_CSR,  OP_GET,    32'(CSR_REPORT), 32'd0,     1'b0, 1'b0, 32'h0, 5'd0, 32'd0, 32'd0},
      '{ROW_CSR,  OP_GET,    32'(CSR_CAPACITY), 32'd0,   1'b0, 1'b0, 32'h0, 5'd0, 32'd0, 32'd0},
      '{ROW_ITEM, OP_PUT,    32'h9,        32'hAAAAAAAA, 1'b0, 1'b0, 32'h0, 5'd0, 32'd0, 32'd0},
      '{ROW_ITEM, OP_FLUSH,  32'h0,        32'h0,        1'b0, 1'b0, 32'h0, 5'd0, 32'd0, 32'd0},
      '{ROW_ITEM, OP_CLEAR,  32'h0,        32'h0,        1'b0, 1'b0, 32'h0, 5'd0, 32'd0, 32'd0},
      '{ROW_CSR,  OP_GET,    32'(CSR_CAPACITY), 32'd31,  1'b0, 1'b0, 32'h0, 5'd0, 32'd0, 32'd0},
      '{ROW_CSR,  OP_GET,    32'(CSR_REPORT), 32'd1,     1'b0, 1'b0, 32'h0, 5'd0, 32'd0, 32'd0}
   };

   logic [CAP_W-1:0] phase_cap [PHASES] = '{5'd16, 5'd4, 5'd0, 5'd31, 5'd9};
   logic             phase_rep [PHASES] = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b0};

   logic                 clock;
   logic                 reset;
   logic                 csr_wr_en;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CAP_W-1:0]     csr_wr_data;

   ltc_req_if #(.KEY_BITS(32), .VALUE_BITS(32)) req_if ();
   ltc_rsp_if #(.ENTRIES(ENTRIES), .KEY_BITS(32), .VALUE_BITS(32)) rsp_if ();

   lru_tag_cache #(
      .ENTRIES(ENTRIES),
      .KEY_BITS(32),
      .VALUE_BITS(32)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_chan(req_if),
      .rsp_chan(rsp_if),
      .csr_wr_en(csr_wr_en),
      .csr_index(csr_index),
      .csr_wr_data(csr_wr_data)
   );

   // cache predictor state
   logic [31:0]      slot_tag   [ENTRIES];
   logic [31:0]      slot_value [ENTRIES];
   logic             slot_live  [ENTRIES];
   int               slot_age   [ENTRIES];
   logic [4:0]       live_count;
   logic [31:0]      get_hits;
   logic [31:0]      get_misses;
   logic [CAP_W-1:0] cfg_capacity;
   logic             cfg_report;

   cache_beat_type expected_beats [$];
   logic [31:0] key_pool [KEY_POOL];

   int  fail_count;
   int  req_no;
   int  beat_no;
   int  report_no;
   int  csr_writes;
   int  idle_cycles;
   bit  hold_rsp;

   always #1 clock = ~clock;

   function automatic int find_tag(logic [31:0] key);
      for (int i = 0; i < ENTRIES; i++)
         if (slot_live[i] && slot_tag[i] == key) return i;
      return -1;
   endfunction

   function automatic int find_age(int age);
      for (int i = 0; i < ENTRIES; i++)
         if (slot_live[i] && slot_age[i] == age) return i;
      return -1;
   endfunction

   function automatic void promote(int idx);
      int age;
      age = slot_age[idx];
      for (int j = 0; j < ENTRIES; j++)
         if (slot_live[j] && slot_age[j] < age) slot_age[j]++;
      slot_age[idx] = 0;
   endfunction

   function automatic void retire(int idx);
      int age;
      age = slot_age[idx];
      slot_live[idx] = 1'b0;
      for (int j = 0; j < ENTRIES; j++)
         if (slot_live[j] && slot_age[j] > age) slot_age[j]--;
      if (live_count != 0) live_count--;
   endfunction

   function automatic cache_beat_type status_beat();
      cache_beat_type b;
      b = '0;
      b.entry_count = live_count;
      b.hit_total   = get_hits;
      b.miss_total  = get_misses;
      b.last        = 1'b1;
      return b;
   endfunction

   function automatic void predict_request(logic [OP_W-1:0] op, logic [31:0] key,
                                           logic [31:0] val);
      int             hit_idx;
      int             old_idx;
      int             free_idx;
      int             room;
      int             n;
      int             e;
      logic           evicted;
      logic [31:0]    ev_key;
      logic [31:0]    ev_val;
      logic [31:0]    walk_key [ENTRIES];
      logic [31:0]    walk_val [ENTRIES];
      cache_beat_type b;
      hit_idx = find_tag(key);
      evicted = 1'b0;
      ev_key  = '0;
      ev_val  = '0;
      case (op)
         OP_GET: begin
            if (hit_idx >= 0) begin
               if (get_hits != CNT_MAX) get_hits++;
               promote(hit_idx);
               b = status_beat();
               b.found     = 1'b1;
               b.value_out = slot_value[hit_idx];
            end else begin
               if (get_misses != CNT_MAX) get_misses++;
               b = status_beat();
            end
         end
         OP_PUT: begin
            if (hit_idx >= 0) begin
               slot_value[hit_idx] = val;
               promote(hit_idx);
            end else begin
               room = (cfg_capacity == 0) ? 1 :
                      (cfg_capacity > ENTRIES) ? ENTRIES : int'(cfg_capacity);
               if (int'(live_count) >= room && live_count != 0) begin
                  old_idx = find_age(int'(live_count) - 1);
                  if (old_idx >= 0) begin
                     ev_key  = slot_tag[old_idx];
                     ev_val  = slot_value[old_idx];
                     evicted = cfg_report;
                     retire(old_idx);
                  end
               end
               free_idx = -1;
               for (int i = 0; i < ENTRIES; i++)
                  if (!slot_live[i] && free_idx < 0) free_idx = i;
               if (free_idx >= 0) begin
                  for (int j = 0; j < ENTRIES; j++)
                     if (slot_live[j]) slot_age[j]++;
                  slot_live[free_idx]  = 1'b1;
                  slot_tag[free_idx]   = key;
                  slot_value[free_idx] = val;
                  slot_age[free_idx]   = 0;
                  live_count++;
               end
            end
            b = status_beat();
            if (evicted) begin
               b.report_valid = 1'b1;
               b.report_key   = ev_key;
               b.report_value = ev_val;
            end
         end
         OP_HAS: begin
            b = status_beat();
            b.found = (hit_idx >= 0);
         end
         OP_REMOVE: begin
            if (hit_idx >= 0) retire(hit_idx);
            b = status_beat();
         end
         OP_CLEAR, OP_FLUSH: begin
            n = 0;
            if (cfg_report) begin
               for (int r = 0; r < int'(live_count) && r < ENTRIES; r++) begin
                  e = find_age(r);
                  if (e >= 0) begin
                     walk_key[n] = slot_tag[e];
                     walk_val[n] = slot_value[e];
                     n++;
                  end
               end
            end
            if (op == OP_CLEAR) begin
               for (int i = 0; i < ENTRIES; i++) slot_live[i] = 1'b0;
               live_count = '0;
            end
            if (n == 0) begin
               expected_beats.push_back(status_beat());
            end else begin
               for (int k = 0; k < n; k++) begin
                  b = status_beat();
                  b.report_valid = 1'b1;
                  b.report_key   = walk_key[k];
                  b.report_value = walk_val[k];
                  b.last         = (k == n - 1);
                  expected_beats.push_back(b);
               end
            end
            return;
         end
         OP_STATS: begin
            get_hits   = '0;
            get_misses = '0;
            b = status_beat();
         end
         default: begin
            b = status_beat();
         end
      endcase
      expected_beats.push_back(b);
   endfunction

   function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected %h, got %h", name, want, got);
         fail_count++;
      end
   endfunction

   task automatic send_req(input logic [OP_W-1:0] op, input logic [31:0] key,
                           input logic [31:0] val);
      int gap;
      gap = ((req_no / 32) % 3 == 2) ? 0 : $urandom_range(0, 7);
      @(negedge clock);
      if (gap != 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_if.valid    <= 1'b1;
      req_if.op       <= op;
      req_if.key_tag  <= key;
      req_if.value_in <= val;
      do @(posedge clock); while (!req_if.ready);
      predict_request(op, key, val);
      req_no++;
   endtask

   task automatic drain_expected();
      @(negedge clock);
      req_if.valid <= 1'b0;
      while (expected_beats.size() != 0) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [CAP_W-1:0] data);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= data;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      if (idx == CSR_CAPACITY) cfg_capacity = data;
      else cfg_report = data[0];
      csr_writes++;
   endtask

   // response side: random stalls, plus one long hold-off on request
   initial begin
      int stall;
      forever begin
         @(negedge clock);
         stall = ((beat_no / 24) % 4 == 3) ? 0 : $urandom_range(0, 7);
         if (hold_rsp) begin
            stall    = HOLD_LEN;
            hold_rsp = 1'b0;
         end
         if (stall != 0) begin
            rsp_if.ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_if.ready <= 1'b1;
         do @(posedge clock); while (!rsp_if.valid);
         beat_no++;
      end
   end

   always @(posedge clock) begin
      cache_beat_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (expected_beats.size() == 0) begin
            $error("unexpected beat: key %h", rsp_if.report_key);
            fail_count++;
         end else begin
            want = expected_beats.pop_front();
            check_field("found", 32'(want.found), 32'(rsp_if.found));
            check_field("value_out", want.value_out, rsp_if.value_out);
            check_field("entry_count", 32'(want.entry_count), 32'(rsp_if.entry_count));
            check_field("hit_total", want.hit_total, rsp_if.hit_total);
            check_field("miss_total", want.miss_total, rsp_if.miss_total);
            check_field("report_valid", 32'(want.report_valid), 32'(rsp_if.report_valid));
            check_field("report_key", want.report_key, rsp_if.report_key);
            check_field("report_value", want.report_value, rsp_if.report_value);
            check_field("last", 32'(want.last), 32'(rsp_if.last));
            if (rsp_if.report_valid) report_no++;
         end
      end
   end

   always @(posedge clock) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      cache_beat_type  lit;
      logic [OP_W-1:0] op;
      logic [31:0]     key;
      int              pick;
      clock           = 1'b0;
      reset           = 1'b1;
      csr_wr_en       = 1'b0;
      csr_index       = '0;
      csr_wr_data     = '0;
      req_if.valid    = 1'b0;
      req_if.op       = OP_GET;
      req_if.key_tag  = '0;
      req_if.value_in = '0;
      rsp_if.ready    = 1'b0;
      fail_count      = 0;
      req_no          = 0;
      beat_no         = 0;
      report_no       = 0;
      csr_writes      = 0;
      idle_cycles     = 0;
      hold_rsp        = 1'b0;
      for (int i = 0; i < ENTRIES; i++) begin
         slot_tag[i]   = '0;
         slot_value[i] = '0;
         slot_live[i]  = 1'b0;
         slot_age[i]   = 0;
      end
      live_count   = '0;
      get_hits     = '0;
      get_misses   = '0;
      cfg_capacity = CAP_RESET;
      cfg_report   = 1'b1;
      for (int i = 0; i < KEY_POOL; i++) key_pool[i] = $urandom;

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed[i]) begin
         if (directed[i].kind == ROW_CSR) begin
            drain_expected();
            csr_write(directed[i].key[CSR_IDX_W-1:0], directed[i].val[CAP_W-1:0]);
         end else begin
            send_req(directed[i].op, directed[i].key, directed[i].val);
            if (directed[i].lit) begin
               expected_beats.delete(expected_beats.size() - 1);
               lit             = '0;
               lit.found       = directed[i].found;
               lit.value_out   = directed[i].value_out;
               lit.entry_count = directed[i].count;
               lit.hit_total   = directed[i].hits;
               lit.miss_total  = directed[i].misses;
               lit.last        = 1'b1;
               expected_beats.push_back(lit);
            end
         end
      end

      for (int ph = 0; ph < PHASES; ph++) begin
         drain_expected();
         csr_write(CSR_CAPACITY, phase_cap[ph]);
         csr_write(CSR_REPORT, 5'(phase_rep[ph]));
         for (int k = 0; k < PHASE_REQS; k++) begin
            if (ph == 0 && k == 20) hold_rsp = 1'b1;
            if (ph == 2 && k == 30) drain_expected();
            pick = $urandom_range(0, 99);
            op = (pick < 30) ? OP_GET :
                 (pick < 65) ? OP_PUT :
                 (pick < 75) ? OP_HAS :
                 (pick < 85) ? OP_REMOVE :
                 (pick < 88) ? OP_CLEAR :
                 (pick < 93) ? OP_FLUSH :
                 (pick < 97) ? OP_STATS : OP_UNUSED;
            key = ($urandom_range(0, 9) == 0) ? $urandom
                                              : key_pool[$urandom_range(0, KEY_POOL - 1)];
            send_req(op, key, $urandom);
         end
      end

      drain_expected();
      repeat (20) @(posedge clock);
      $display("Covered %0d requests and %0d response beats, %0d of them reported entries,",
               req_no, beat_no, report_no);
      $display("across %0d register writes including capacity 0 and 31.", csr_writes);
      if (fail_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

>>> lru_tag_cache.f
hdl/ltc_pkg.sv
hdl/ltc_if.sv
hdl/ltc_datapath.sv
hdl/ltc_ctrl.sv
hdl/lru_tag_cache.sv
verif/lru_tag_cache_tb.sv
